### design/atlrp_pkg.sv
// ----------------------------------------------------------------------------
// atlrp_pkg
// Types and match strings shared by the modem receive parser.
// ----------------------------------------------------------------------------
`default_nettype none
package atlrp_pkg;

  // Parser mode
  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_WAITOK = 3'd1,
    M_LEN    = 3'd2,
    M_DATA   = 3'd3,
    M_SEND   = 3'd4
  } mode_e;

  // Result kinds
  typedef enum logic [2:0] {
    K_DATA    = 3'd0,
    K_CONNECT = 3'd1,
    K_CLOSE   = 3'd2,
    K_SEND_OK = 3'd3,
    K_OK      = 3'd4,
    K_DROP    = 3'd5
  } kind_e;

  // Sequencer state
  typedef enum logic {
    S_READY = 1'b0,
    S_RUN   = 1'b1
  } fsm_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  conn_id;
    logic [7:0]  data_byte;
    logic [15:0] remaining;
    logic [4:0]  open_map;
    logic        last;
  } res_t;

  typedef struct packed {
    logic push;   // load a new result into the holding slot
    logic flush;  // no more results for this item
  } res_ctl_t;

  typedef struct packed {
    logic can_push;
    logic drain_ok;
  } res_stat_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] PAT_SEND_OK [9] =
    '{8'h53, 8'h45, 8'h4E, 8'h44, 8'h20, 8'h4F, 8'h4B, 8'h0D, 8'h0A};
  localparam logic [7:0] PAT_IPD [5] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};
  localparam logic [7:0] PAT_OK [6] = '{8'h0D, 8'h0A, 8'h4F, 8'h4B, 8'h0D, 8'h0A};
  localparam logic [7:0] PAT_CONNECT [9] =
    '{8'h2C, 8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h0D};
  localparam logic [7:0] PAT_CLOSED [9] =
    '{8'h2C, 8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45, 8'h44, 8'h0D, 8'h0A};
  localparam logic [7:0] PAT_CRLF [2] = '{8'h0D, 8'h0A};

endpackage
`default_nettype wire

### design/atlrp_if.sv
// ----------------------------------------------------------------------------
// atlrp_in_if / atlrp_out_if
// Valid/ready channels for received bytes and parser results.
// ----------------------------------------------------------------------------
`default_nettype none
interface atlrp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface atlrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  conn_id;
  logic [7:0]  data_byte;
  logic [15:0] remaining;
  logic [4:0]  open_map;
  logic        last;

  modport source (output valid, kind, conn_id, data_byte, remaining, open_map, last,
                  input ready);
  modport sink (input valid, kind, conn_id, data_byte, remaining, open_map, last,
                output ready);
endinterface
`default_nettype wire

### design/atlrp_res_stage.sv
// ----------------------------------------------------------------------------
// atlrp_res_stage
// Holding slot plus output register; marks the final result of an item.
// ----------------------------------------------------------------------------
`default_nettype none
module atlrp_res_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire atlrp_pkg::res_ctl_t  ctl_i,
  input  wire atlrp_pkg::res_t      res_i,
  output atlrp_pkg::res_stat_t      stat_o,
  atlrp_out_if.source               ev_o
);
  import atlrp_pkg::*;

  res_t held_q, out_q;
  logic held_v_q, out_v_q;
  logic out_free;

  assign out_free        = !out_v_q || ev_o.ready;
  assign stat_o.can_push = !held_v_q || out_free;
  assign stat_o.drain_ok = !held_v_q || out_free;

  // Control: slot and output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (ctl_i.push) begin
        held_v_q <= 1'b1;
        out_v_q  <= held_v_q || (out_v_q && !ev_o.ready);
      end else if (ctl_i.flush && held_v_q && out_free) begin
        held_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end else if (out_v_q && ev_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload: a later result proves the held one was not last
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      held_q <= res_i;
      if (held_v_q) out_q <= {held_q[$bits(res_t)-1:1], 1'b0};
    end else if (ctl_i.flush && held_v_q && out_free) begin
      out_q <= {held_q[$bits(res_t)-1:1], 1'b1};
    end
  end

  assign ev_o.valid     = out_v_q;
  assign ev_o.kind      = out_q.kind;
  assign ev_o.conn_id   = out_q.conn_id;
  assign ev_o.data_byte = out_q.data_byte;
  assign ev_o.remaining = out_q.remaining;
  assign ev_o.open_map  = out_q.open_map;
  assign ev_o.last      = out_q.last;

endmodule
`default_nettype wire

### design/at_link_receive_parser.sv
// ----------------------------------------------------------------------------
// at_link_receive_parser
// Receive-side parser for the byte stream of a serial WiFi modem.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one item per received byte (cmd 0) or a send notice (cmd 1).
//   ev_o carries parser results: payload bytes, connect/close events, send ok,
//   ok after payload and dropped bytes; last marks the final result of an item.
//   Items are accepted one at a time. After the accept cycle the sequencer runs
//   one parse action per cycle on the lookahead window (one byte compare set,
//   one length update through the shared multiply-add unit) while the result
//   path has room, then settles and returns to ready.
//   The result path is one holding slot plus the output register: when the
//   receiver stalls, parsing halts at the next result and rx_i stays not ready.
//   Reset clears mode, counts and the open-connection map; window contents are
//   don't-care until written.
// ----------------------------------------------------------------------------
`default_nettype none
module at_link_receive_parser #(
  parameter int MAX_CONN  = 5,
  parameter int LOOKAHEAD = 10
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  atlrp_in_if.sink     rx_i,
  atlrp_out_if.source  ev_o
);
  import atlrp_pkg::*;

  localparam int CW = $clog2(LOOKAHEAD + 1);
  localparam int IW = $clog2(LOOKAHEAD);
  localparam logic [CW-1:0] N1  = CW'(1);
  localparam logic [CW-1:0] N2  = CW'(2);
  localparam logic [CW-1:0] N6  = CW'(6);
  localparam logic [CW-1:0] N7  = CW'(7);
  localparam logic [CW-1:0] N9  = CW'(9);
  localparam logic [CW-1:0] N10 = CW'(10);
  localparam logic [CW-1:0] N11 = CW'(11);
  localparam logic [CW-1:0] NLA = CW'(LOOKAHEAD);

  logic [7:0]          w_q [LOOKAHEAD];
  logic [7:0]          w_d [LOOKAHEAD];
  logic [CW-1:0]       cnt_q, cnt_d;
  mode_e               mode_q, mode_d;
  fsm_e                fsm_q, fsm_d;
  logic                rts_q, rts_d;
  logic [15:0]         len_q, len_d;
  logic [3:0]          conn_q, conn_d;
  logic [MAX_CONN-1:0] flags_q, flags_d;
  logic                skip_q, skip_d;

  // step results
  logic                chg, emit, apply;
  res_t                em;
  logic [CW-1:0]       sh;
  mode_e               mode_n;
  logic                rts_n, skip_n;
  logic [15:0]         len_n;
  logic [3:0]          conn_n;
  logic [MAX_CONN-1:0] flags_n;

  logic hit_ipd, hit_send, hit_ok, hit_conn, hit_close, hit_crlf;
  logic [3:0]  digit0;
  logic        is_digit;
  logic [19:0] len10;
  logic [15:0] len_dec;

  res_ctl_t  ctl;
  res_stat_t stat;

  // Pattern compares against the window head
  always_comb begin
    hit_ipd   = 1'b1;
    hit_send  = 1'b1;
    hit_ok    = 1'b1;
    hit_conn  = 1'b1;
    hit_close = 1'b1;
    hit_crlf  = 1'b1;
    for (int i = 0; i < 5; i++) if (w_q[i] != PAT_IPD[i]) hit_ipd = 1'b0;
    for (int i = 0; i < 9; i++) if (w_q[i] != PAT_SEND_OK[i]) hit_send = 1'b0;
    for (int i = 0; i < 6; i++) if (w_q[i] != PAT_OK[i]) hit_ok = 1'b0;
    for (int i = 0; i < 9; i++) if (w_q[i+1] != PAT_CONNECT[i]) hit_conn = 1'b0;
    for (int i = 0; i < 9; i++) if (w_q[i+1] != PAT_CLOSED[i]) hit_close = 1'b0;
    for (int i = 0; i < 2; i++) if (w_q[i] != PAT_CRLF[i]) hit_crlf = 1'b0;
  end

  // Shared length unit: times ten plus digit, or decrement
  assign digit0   = w_q[0][3:0];
  assign is_digit = (w_q[0] >= CH_ZERO) && (w_q[0] <= CH_NINE);
  assign len10    = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1) + {16'b0, digit0};
  assign len_dec  = len_q - 16'd1;

  // One parse action
  always_comb begin
    chg     = 1'b0;
    emit    = 1'b0;
    em      = '0;
    sh      = '0;
    mode_n  = mode_q;
    rts_n   = rts_q;
    len_n   = len_q;
    conn_n  = conn_q;
    flags_n = flags_q;
    skip_n  = skip_q;
    unique case (mode_q)
      M_IDLE: begin
        if (cnt_q >= N10) begin
          chg = 1'b1;
          if (hit_ipd) begin
            conn_n = w_q[5][3:0];
            sh     = N7;
            len_n  = '0;
            mode_n = M_LEN;
          end else if (hit_conn) begin
            for (int i = 0; i < MAX_CONN; i++) if (digit0 == 4'(i)) flags_n[i] = 1'b1;
            emit       = 1'b1;
            em.kind    = K_CONNECT;
            em.conn_id = digit0;
            // drop the byte after CONNECT now or on arrival
            if (cnt_q > N10) sh = N11;
            else begin
              sh     = N10;
              skip_n = 1'b1;
            end
          end else if (hit_close) begin
            for (int i = 0; i < MAX_CONN; i++) if (digit0 == 4'(i)) flags_n[i] = 1'b0;
            emit       = 1'b1;
            em.kind    = K_CLOSE;
            em.conn_id = digit0;
            sh         = N10;
          end else if (hit_crlf) begin
            sh = N2;
          end else begin
            sh = N1;
          end
        end
      end
      M_SEND: begin
        if (cnt_q >= N9) begin
          chg = 1'b1;
          if (hit_send) begin
            sh      = N9;
            emit    = 1'b1;
            em.kind = K_SEND_OK;
            mode_n  = M_IDLE;
          end else if (hit_ipd) begin
            conn_n = w_q[5][3:0];
            sh     = N7;
            len_n  = '0;
            mode_n = M_LEN;
            rts_n  = 1'b1;
          end else begin
            sh = N1;
          end
        end
      end
      M_LEN: begin
        if (cnt_q != '0) begin
          chg = 1'b1;
          sh  = N1;
          if (w_q[0] == CH_COLON) begin
            mode_n = (len_q != '0) ? M_DATA : M_WAITOK;
          end else if (is_digit) begin
            len_n = (len10[19:16] != '0) ? 16'hFFFF : len10[15:0];
          end
        end
      end
      M_DATA: begin
        if (len_q == '0) begin
          chg    = 1'b1;
          mode_n = M_WAITOK;
        end else if (cnt_q != '0) begin
          chg          = 1'b1;
          sh           = N1;
          len_n        = len_dec;
          emit         = 1'b1;
          em.kind      = K_DATA;
          em.conn_id   = conn_q;
          em.data_byte = w_q[0];
          em.remaining = len_dec;
          if (len_dec == '0) mode_n = M_WAITOK;
        end
      end
      M_WAITOK: begin
        if (cnt_q >= N6) begin
          chg  = 1'b1;
          emit = 1'b1;
          if (hit_ok) begin
            sh         = N6;
            em.kind    = K_OK;
            em.conn_id = conn_q;
            mode_n     = rts_q ? M_SEND : M_IDLE;
          end else begin
            sh           = N1;
            em.kind      = K_DROP;
            em.data_byte = w_q[0];
            mode_n       = M_IDLE;
          end
          rts_n = 1'b0;
        end
      end
      default: begin
        chg    = 1'b1;
        mode_n = M_IDLE;
      end
    endcase
    for (int i = 0; i < 5; i++) if (i < MAX_CONN) em.open_map[i] = flags_n[i];
  end

  // Sequencer: accept, then one action per cycle while results have room, until settled
  assign apply     = chg && (!emit || stat.can_push);
  assign ctl.push  = (fsm_q == S_RUN) && apply && emit;
  assign ctl.flush = (fsm_q == S_RUN) && !chg;
  assign rx_i.ready = (fsm_q == S_READY);

  always_comb begin
    fsm_d   = fsm_q;
    w_d     = w_q;
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    rts_d   = rts_q;
    len_d   = len_q;
    conn_d  = conn_q;
    flags_d = flags_q;
    skip_d  = skip_q;
    unique case (fsm_q)
      S_READY: begin
        if (rx_i.valid) begin
          fsm_d = S_RUN;
          if (rx_i.cmd) begin
            if (mode_q == M_IDLE) mode_d = M_SEND;
          end else if (skip_q) begin
            skip_d = 1'b0;
          end else if (cnt_q < NLA) begin
            w_d[cnt_q[IW-1:0]] = rx_i.rx_byte;
            cnt_d              = cnt_q + N1;
          end
        end
      end
      S_RUN: begin
        if (apply) begin
          mode_d  = mode_n;
          rts_d   = rts_n;
          len_d   = len_n;
          conn_d  = conn_n;
          flags_d = flags_n;
          skip_d  = skip_n;
          // drop consumed bytes from the window head
          for (int i = 0; i < LOOKAHEAD; i++) begin
            if (i + int'(sh) < LOOKAHEAD) w_d[i] = w_q[IW'(i + int'(sh))];
          end
          cnt_d = (sh >= cnt_q) ? '0 : cnt_q - sh;
        end else if (!chg && stat.drain_ok) begin
          fsm_d = S_READY;
        end
      end
      default: fsm_d = S_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q   <= S_READY;
      cnt_q   <= '0;
      mode_q  <= M_IDLE;
      rts_q   <= 1'b0;
      len_q   <= '0;
      conn_q  <= '0;
      flags_q <= '0;
      skip_q  <= 1'b0;
    end else begin
      fsm_q   <= fsm_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
      rts_q   <= rts_d;
      len_q   <= len_d;
      conn_q  <= conn_d;
      flags_q <= flags_d;
      skip_q  <= skip_d;
    end
  end

  // Window bytes
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  atlrp_res_stage u_res (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .res_i  (em),
    .stat_o (stat),
    .ev_o   (ev_o)
  );

  // Checks
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_i.valid && rx_i.ready |=> !rx_i.ready)
    else $error("item accepted while previous one in flight");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NLA)
    else $error("window count beyond lookahead");
  a_idle_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_i.ready && mode_q == M_IDLE |-> cnt_q < N10)
    else $error("idle parser left a full window");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.push |-> stat.can_push)
    else $error("result pushed with no room");

endmodule
`default_nettype wire

### sim/tb_at_link_receive_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_at_link_receive_parser
// Self-checking bench for the modem receive parser.
// ----------------------------------------------------------------------------
// Drives received bytes and send notices, predicts each event with a local
// copy of the parser state, and compares every result in order. The tests
// cover directed events and data frames, one saturated-length frame, random
// traffic under several idle and stall mixes, and a long receiver hold.
// ----------------------------------------------------------------------------
module tb_at_link_receive_parser;
  import atlrp_pkg::*;

  localparam int NUM_CONN  = 5;
  localparam int WIN_DEPTH = 10;
  localparam int MAX_EVTS  = 12;
  localparam int WDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] CR = 8'h0D;
  localparam logic [7:0] LF = 8'h0A;
  localparam logic [71:0] STR_SEND_OK = {"SEND OK", CR, LF};
  localparam logic [71:0] STR_IPD     = {32'h0, "+IPD,"};
  localparam logic [71:0] STR_OK      = {24'h0, CR, LF, "OK", CR, LF};
  localparam logic [71:0] STR_CONNECT = {",CONNECT", CR};
  localparam logic [71:0] STR_CLOSED  = {",CLOSED", CR, LF};
  localparam logic [71:0] STR_CRLF    = {56'h0, CR, LF};
  localparam bit CMD_BYTE = 1'b0;
  localparam bit CMD_SEND = 1'b1;

  logic clk_i;
  logic rst_ni;

  atlrp_in_if  rx_if ();
  atlrp_out_if ev_if ();

  at_link_receive_parser u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .ev_o  (ev_if)
  );

  // Parser shadow state
  logic [7:0] win [WIN_DEPTH] = '{default: 8'h00};
  int         win_cnt = 0;
  mode_e      pmode = M_IDLE;
  bit         back_to_send = 1'b0;
  int         msg_len = 0;
  logic [3:0] msg_id = 4'h0;
  logic [4:0] open_bits = 5'h0;
  bit         drop_next = 1'b0;
  res_t       item_evts[$];
  res_t       exp_evts[$];

  int  err_cnt = 0;
  int  src_idle_pct;
  int  snk_stall_pct;
  bit  hold_req;
  bit  hold_seen = 1'b0;
  int  hold_cnt = 0;
  int  quiet_cycles = 0;
  int  sent_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void add_evt(kind_e k, logic [3:0] c, logic [7:0] d, logic [15:0] r);
    res_t e;
    if (item_evts.size() >= MAX_EVTS) return;
    e.kind = k; e.conn_id = c; e.data_byte = d; e.remaining = r;
    e.open_map = open_bits; e.last = 1'b0;
    item_evts.push_back(e);
  endfunction

  function automatic void pop_bytes(int n);
    if (n >= win_cnt) begin
      win_cnt = 0;
      return;
    end
    for (int i = 0; i < win_cnt - n; i++) win[i] = win[i + n];
    win_cnt -= n;
  endfunction

  function automatic bit win_has(logic [71:0] pat, int len, int off);
    if (off + len > win_cnt) return 1'b0;
    for (int i = 0; i < len; i++)
      if (win[off + i] != pat[8*(len-1-i) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [3:0] conn_digit(logic [7:0] b);
    logic [7:0] t;
    t = b - 8'h30;
    return t[3:0];
  endfunction

  function automatic void open_header();
    msg_id = conn_digit(win[5]);
    pop_bytes(7);
    msg_len = 0;
    pmode = M_LEN;
  endfunction

  // One parse action on the window; return 0 when nothing can advance
  function automatic bit parse_action();
    logic [3:0] id;
    logic [7:0] b;
    case (pmode)
      M_IDLE: begin
        if (win_cnt < 10) return 1'b0;
        if (win_has(STR_IPD, 5, 0)) begin
          open_header();
        end else if (win_has(STR_CONNECT, 9, 1)) begin
          id = conn_digit(win[0]);
          if (id < NUM_CONN) open_bits[id] = 1'b1;
          pop_bytes(10);
          add_evt(K_CONNECT, id, 8'h00, 16'h0);
          if (win_cnt > 0) pop_bytes(1);
          else drop_next = 1'b1;
        end else if (win_has(STR_CLOSED, 9, 1)) begin
          id = conn_digit(win[0]);
          if (id < NUM_CONN) open_bits[id] = 1'b0;
          pop_bytes(10);
          add_evt(K_CLOSE, id, 8'h00, 16'h0);
        end else if (win_has(STR_CRLF, 2, 0)) begin
          pop_bytes(2);
        end else begin
          pop_bytes(1);
        end
      end
      M_SEND: begin
        if (win_cnt < 9) return 1'b0;
        if (win_has(STR_SEND_OK, 9, 0)) begin
          pop_bytes(9);
          add_evt(K_SEND_OK, 4'h0, 8'h00, 16'h0);
          pmode = M_IDLE;
        end else if (win_has(STR_IPD, 5, 0)) begin
          open_header();
          back_to_send = 1'b1;
        end else begin
          pop_bytes(1);
        end
      end
      M_LEN: begin
        if (win_cnt == 0) return 1'b0;
        b = win[0];
        pop_bytes(1);
        if (b == 8'h3A) begin
          pmode = (msg_len != 0) ? M_DATA : M_WAITOK;
        end else if (b >= 8'h30 && b <= 8'h39) begin
          msg_len = msg_len * 10 + (b - 8'h30);
          if (msg_len > 65535) msg_len = 65535;
        end
      end
      M_DATA: begin
        if (msg_len == 0) begin
          pmode = M_WAITOK;
          return 1'b1;
        end
        if (win_cnt == 0) return 1'b0;
        b = win[0];
        pop_bytes(1);
        msg_len--;
        add_evt(K_DATA, msg_id, b, msg_len[15:0]);
        if (msg_len == 0) pmode = M_WAITOK;
      end
      M_WAITOK: begin
        if (win_cnt < 6) return 1'b0;
        if (win_has(STR_OK, 6, 0)) begin
          pop_bytes(6);
          add_evt(K_OK, msg_id, 8'h00, 16'h0);
          pmode = back_to_send ? M_SEND : M_IDLE;
        end else begin
          b = win[0];
          pop_bytes(1);
          add_evt(K_DROP, 4'h0, b, 16'h0);
          pmode = M_IDLE;
        end
        back_to_send = 1'b0;
      end
      default: pmode = M_IDLE;
    endcase
    return 1'b1;
  endfunction

  // Apply one accepted item and queue the events it causes
  function automatic void predict_events(bit c, logic [7:0] b);
    item_evts.delete();
    if (c == CMD_SEND) begin
      if (pmode == M_IDLE) pmode = M_SEND;
    end else if (drop_next) begin
      drop_next = 1'b0;
    end else if (win_cnt < WIN_DEPTH) begin
      win[win_cnt] = b;
      win_cnt++;
    end
    for (int g = 0; g < 4 * WIN_DEPTH + 8; g++)
      if (!parse_action()) break;
    if (item_evts.size() > 0) item_evts[item_evts.size() - 1].last = 1'b1;
    foreach (item_evts[i]) exp_evts.push_back(item_evts[i]);
  endfunction

  // Predict on input accepts, check on output accepts
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && rx_if.valid && rx_if.ready) predict_events(rx_if.cmd, rx_if.rx_byte);
    if (rst_ni && ev_if.valid && ev_if.ready) begin
      if (exp_evts.size() == 0) begin
        $display("%0t: unexpected event kind %0d data %h", $time, ev_if.kind, ev_if.data_byte);
        err_cnt++;
      end else begin
        e = exp_evts.pop_front();
        if (ev_if.kind !== e.kind || ev_if.conn_id !== e.conn_id ||
            ev_if.data_byte !== e.data_byte || ev_if.remaining !== e.remaining ||
            ev_if.open_map !== e.open_map || ev_if.last !== e.last) begin
          $display("%0t: mismatch exp kind %0d id %0d data %h rem %0d map %b last %b",
                   $time, e.kind, e.conn_id, e.data_byte, e.remaining, e.open_map, e.last);
          $display("%0t:          got kind %0d id %0d data %h rem %0d map %b last %b",
                   $time, ev_if.kind, ev_if.conn_id, ev_if.data_byte, ev_if.remaining,
                   ev_if.open_map, ev_if.last);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      ev_if.ready <= 1'b0;
    end else begin
      ev_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d events outstanding", $time, exp_evts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(bit c, logic [7:0] b);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    rx_if.cmd     <= c;
    rx_if.rx_byte <= b;
    rx_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!rx_if.ready);
    sent_cnt++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_BYTE, s[i]);
  endtask

  task automatic send_crlf();
    send_item(CMD_BYTE, CR);
    send_item(CMD_BYTE, LF);
  endtask

  // Hold the input until every predicted event has been taken
  task automatic wait_drain();
    rx_if.valid <= 1'b0;
    while (exp_evts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Data frame: header, length, payload, then the OK trailer (or a broken one)
  task automatic send_frame(logic [7:0] id_ch, string len_txt, int nbytes, bit good_ok);
    send_text("+IPD,");
    send_item(CMD_BYTE, id_ch);
    send_text({",", len_txt, ":"});
    repeat (nbytes) send_item(CMD_BYTE, 8'($urandom_range(255)));
    send_crlf();
    if (good_ok) send_text("OK");
    else send_text("OX");
    send_crlf();
  endtask

  task automatic send_event(logic [7:0] id_ch, bit is_open);
    send_item(CMD_BYTE, id_ch);
    if (is_open) begin
      send_text(",CONNECT");
      send_item(CMD_BYTE, CR);
      send_item(CMD_BYTE, LF);
    end else begin
      send_text(",CLOSED");
      send_crlf();
    end
  endtask

  task automatic send_ack();
    send_text("SEND OK");
    send_crlf();
  endtask

  task automatic test_events();
    send_event("0", 1'b1);
    send_event("4", 1'b1);
    send_event("7", 1'b1);
    send_event("0", 1'b0);
    send_event("9", 1'b0);
    send_crlf();
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h00);
    wait_drain();
  endtask

  task automatic test_frames();
    send_frame("A", "1x2", 12, 1'b1);
    send_frame("0", "0", 0, 1'b1);
    send_frame("9", "3", 3, 1'b0);
    send_frame("3", "1", 1, 1'b1);
    send_item(CMD_SEND, 8'h00);
    send_frame("2", "2", 2, 1'b1);
    send_item(CMD_SEND, 8'h00);
    send_ack();
    send_frame("1", "4", 4, 1'b1);
    wait_drain();
  endtask

  // The frame never completes, so the parser stays in payload; run it last
  task automatic test_saturated_length();
    send_frame("1", "99999", 8, 1'b1);
    wait_drain();
  endtask

  task automatic random_burst();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) begin
      send_frame(8'(8'h30 + $urandom_range(9)), $sformatf("%0d", $urandom_range(8)),
                 0, 1'b1);
      // the length field is random but no payload bytes follow
    end else if (sel < 50) begin
      send_event(8'(8'h30 + $urandom_range(9)), 1'b1);
    end else if (sel < 60) begin
      send_event(8'(8'h30 + $urandom_range(9)), 1'b0);
    end else if (sel < 72) begin
      send_item(CMD_SEND, 8'($urandom_range(255)));
      if ($urandom_range(2) == 0) send_frame(8'(8'h30 + $urandom_range(4)), "2", 2, 1'b1);
      send_ack();
    end else if (sel < 77) begin
      send_crlf();
    end else if (sel < 87) begin
      repeat ($urandom_range(1, 3)) send_item($urandom_range(7) == 0, 8'($urandom_range(255)));
    end else begin
      send_text("+IPD,");
      send_item(CMD_BYTE, 8'($urandom_range(255)));
      send_text(",3:");
      repeat (3) send_item(CMD_BYTE, 8'($urandom_range(255)));
      send_item(CMD_BYTE, 8'($urandom_range(255)));
      send_crlf();
    end
  endtask

  task automatic random_frame_mix();
    int n;
    n = $urandom_range(8);
    if ($urandom_range(1) == 0) begin
      send_frame(8'(8'h30 + $urandom_range(9)), $sformatf("%0d", n), n,
                 $urandom_range(5) != 0);
    end else begin
      random_burst();
    end
  endtask

  task automatic test_random(int src_pct, int snk_pct, int n_items);
    int goal;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    goal = sent_cnt + n_items;
    while (sent_cnt < goal) random_frame_mix();
    wait_drain();
  endtask

  // Stall the receiver for a long stretch while frames keep coming
  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req = ~hold_req;
    send_frame("2", "20", 20, 1'b1);
    send_frame("3", "6", 6, 1'b1);
    wait_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    rx_if.valid = 1'b0;
    rx_if.cmd = CMD_BYTE;
    rx_if.rx_byte = 8'h00;
    sent_cnt = 0;
    src_idle_pct = 0; snk_stall_pct = 0;
    hold_req = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_events();
    test_frames();
    test_random(0, 0, 30);
    test_random(50, 0, 30);
    test_random(0, 50, 30);
    test_random(26, 26, 30);
    test_backpressure();
    test_saturated_length();

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
